@@ design/rble_pkg.sv @@
// ---------------------------------------------------------------------------
// rble_pkg: shared definitions for the line extractor
// Store depth, derived widths, character codes, status codes and states.
// ---------------------------------------------------------------------------
package rble_pkg;

   localparam int BUF_DEPTH = 64;
   localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
   localparam int LEN_W     = 6;

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BUF_DEPTH);
   localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(BUF_DEPTH);

   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   typedef enum logic [1:0] {
      STAT_STORED  = 2'd0,
      STAT_DROPPED = 2'd1,
      STAT_LINE    = 2'd2,
      STAT_NOLINE  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_SKIP_RD,
      ST_SKIP_CHK,
      ST_DONE
   } state_type;

   // position plus offset, modulo depth; offset below depth
   function automatic logic [ADDR_W-1:0] wrap_add(logic [ADDR_W-1:0] p,
                                                  logic [CNT_W-1:0]  k);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(p) + (CNT_W + 1)'(k);
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      return ADDR_W'(sum);
   endfunction

   function automatic logic is_eol(logic [7:0] c);
      return (c == CH_LF) || (c == CH_CR);
   endfunction

endpackage

@@ design/ring_buffer_line_extractor_core.sv @@
// Push: ST_PUSH registers the result word once the output is free, then returns to ST_IDLE.
// Pop: ST_SCAN_RD/ST_SCAN_CHK read and check each byte up to the LF, ST_EMIT_RD/ST_EMIT_OUT
// read and emit each line byte, ST_SKIP_RD/ST_SKIP_CHK skip each CR/LF that follows, and
// ST_DONE finishes before ST_IDLE; every read goes through the one read port of the byte store.
// One word in flight at a time; a stalled result word holds the machine. Reset (synchronous,
// active high) clears positions, fill count, state and valid; the byte store is not cleared.
// ---------------------------------------------------------------------------
// ring_buffer_line_extractor_core
// Circular byte store with line framing: pushes append bytes (dropped when full), pops hand out
// one complete line byte by byte, dropping the CR/LF terminator, or a no-line word if none.
// ---------------------------------------------------------------------------
module ring_buffer_line_extractor_core
   import rble_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_cmd,
   input  logic [7:0]       req_in_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic [LEN_W-1:0] rsp_line_length
);

   logic [7:0] mem [BUF_DEPTH];

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] rp_ff, rp_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic              prev_cr_ff, prev_cr_in;
   logic [7:0]        byte_ff, byte_in;
   logic [7:0]        rd_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;

   logic              rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              out_free, emit;
   logic [CNT_W-1:0]  scan_len;
   logic              emit_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_len  = prev_cr_ff ? (k_ff - CNT_W'(1)) : k_ff;
   assign emit_last = (k_ff + CNT_W'(1)) == len_ff;

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_line_length = rsp_len_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_cmd ? ST_SCAN_RD : ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            state_in = (k_ff < fill_ff) ? ST_SCAN_CHK : ST_SKIP_RD;
         end
         ST_SCAN_CHK: begin
            if (rd_data_ff == CH_LF) begin
               state_in = (scan_len == '0) ? ST_SKIP_RD : ST_EMIT_RD;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (out_free) begin
               state_in = emit_last ? ST_SKIP_RD : ST_EMIT_RD;
            end
         end
         ST_SKIP_RD: begin
            state_in = (fill_ff != '0) ? ST_SKIP_CHK : ST_DONE;
         end
         ST_SKIP_CHK: begin
            state_in = is_eol(rd_data_ff) ? ST_SKIP_RD : ST_DONE;
         end
         ST_DONE: begin
            if ((len_ff != '0) || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and result word
   always_comb begin
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      fill_in       = fill_ff;
      k_in          = k_ff;
      len_in        = len_ff;
      prev_cr_in    = prev_cr_ff;
      byte_in       = byte_ff;
      rd_en         = 1'b0;
      rd_addr       = rp_ff;
      wr_en         = 1'b0;
      emit          = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_len_in    = rsp_len_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               byte_in    = req_in_byte;
               k_in       = '0;
               len_in     = '0;
               prev_cr_in = 1'b0;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               emit          = 1'b1;
               rsp_byte_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_len_in    = '0;
               if (fill_ff >= FULL_CNT) begin
                  rsp_status_in = STAT_DROPPED;
               end else begin
                  rsp_status_in = STAT_STORED;
                  wr_en         = 1'b1;
                  wp_in         = wrap_add(wp_ff, CNT_W'(1));
                  fill_in       = fill_ff + CNT_W'(1);
               end
            end
         end
         ST_SCAN_RD: begin
            if (k_ff < fill_ff) begin
               rd_en   = 1'b1;
               rd_addr = wrap_add(rp_ff, k_ff);
            end
         end
         ST_SCAN_CHK: begin
            if (rd_data_ff == CH_LF) begin
               len_in = scan_len;
               k_in   = '0;
            end else begin
               prev_cr_in = (rd_data_ff == CH_CR);
               k_in       = k_ff + CNT_W'(1);
            end
         end
         ST_EMIT_RD: begin
            rd_en   = 1'b1;
            rd_addr = wrap_add(rp_ff, k_ff);
         end
         ST_EMIT_OUT: begin
            if (out_free) begin
               emit          = 1'b1;
               rsp_status_in = STAT_LINE;
               rsp_byte_in   = rd_data_ff;
               rsp_last_in   = emit_last;
               rsp_len_in    = LEN_W'(len_ff);
               k_in          = k_ff + CNT_W'(1);
               if (emit_last) begin
                  rp_in   = wrap_add(rp_ff, len_ff);
                  fill_in = fill_ff - len_ff;
               end
            end
         end
         ST_SKIP_RD: begin
            if (fill_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = rp_ff;
            end
         end
         ST_SKIP_CHK: begin
            if (is_eol(rd_data_ff)) begin
               rp_in   = wrap_add(rp_ff, CNT_W'(1));
               fill_in = fill_ff - CNT_W'(1);
            end
         end
         ST_DONE: begin
            if ((len_ff == '0) && out_free) begin
               emit          = 1'b1;
               rsp_status_in = STAT_NOLINE;
               rsp_byte_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_len_in    = '0;
               if (fill_ff == FULL_CNT) begin
                  rp_in   = '0;
                  wp_in   = '0;
                  fill_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   // byte store, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= byte_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      len_ff        <= len_in;
      prev_cr_ff    <= prev_cr_in;
      byte_ff       <= byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_len_ff    <= rsp_len_in;
   end

endmodule

@@ bench/ring_buffer_line_extractor_core_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ring_buffer_line_extractor_core_tb
// Self-checking bench for the line extractor. Push and pop commands are sent
// with random gaps on both channels. Every accepted command goes through an
// in-bench copy of the store and its positions. Each result word is checked
// field by field against the oldest word still outstanding.
// ---------------------------------------------------------------------------
module ring_buffer_line_extractor_core_tb
   import rble_pkg::*;
();

   localparam logic CMD_PUSH    = 1'b0;
   localparam logic CMD_POP     = 1'b1;
   localparam int   QUIET_LIMIT = 4000;
   localparam int   TAIL_CYCLES = 400;
   localparam int   RAND_ITEMS  = 300;

   typedef struct packed {
      logic       drain;
      logic       cmd;
      logic [7:0] data;
   } req_word_type;

   typedef struct {
      status_type       status;
      logic [7:0]       data;
      logic             last;
      logic [LEN_W-1:0] len;
   } rsp_word_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic             req_cmd;
   logic [7:0]       req_in_byte;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [1:0]       rsp_status;
   logic [7:0]       rsp_out_byte;
   logic             rsp_last;
   logic [LEN_W-1:0] rsp_line_length;

   req_word_type cmd_q[$];
   rsp_word_type line_words_q[$];
   req_word_type next_req;
   rsp_word_type exp_word;

   // bench copy of the framer state
   logic [7:0]        text_store [BUF_DEPTH];
   logic [ADDR_W-1:0] rd_pos;
   logic [ADDR_W-1:0] wr_pos;
   logic [CNT_W-1:0]  fill_cnt;

   int offered_cnt  = 0;
   int accepted_cnt = 0;
   int quiet_cycles = 0;
   int req_gap      = 0;
   int req_calm     = 0;
   int rsp_gap      = 0;
   int rsp_calm     = 0;
   bit drain_next   = 1'b0;
   bit mismatch_seen = 1'b0;

   ring_buffer_line_extractor_core dut (.*);

   always #4 clock = ~clock;

   function automatic logic [ADDR_W-1:0] ring_idx(int k);
      return ADDR_W'((int'(rd_pos) + k) % BUF_DEPTH);
   endfunction

   function automatic void expect_word(status_type s, logic [7:0] d, logic l, int n);
      rsp_word_type w;
      w.status = s;
      w.data   = d;
      w.last   = l;
      w.len    = LEN_W'(n);
      line_words_q.push_back(w);
   endfunction

   function automatic void drop_eol();
      while (fill_cnt != 0 &&
             (text_store[rd_pos] == CH_LF || text_store[rd_pos] == CH_CR)) begin
         rd_pos   = ring_idx(1);
         fill_cnt = fill_cnt - CNT_W'(1);
      end
   endfunction

   function automatic void framer_push(logic [7:0] b);
      if (int'(fill_cnt) >= BUF_DEPTH) begin
         expect_word(STAT_DROPPED, 8'h00, 1'b1, 0);
      end else begin
         text_store[wr_pos] = b;
         wr_pos   = ADDR_W'((int'(wr_pos) + 1) % BUF_DEPTH);
         fill_cnt = fill_cnt + CNT_W'(1);
         expect_word(STAT_STORED, 8'h00, 1'b1, 0);
      end
   endfunction

   function automatic void framer_pop();
      int lf_at;
      int len;
      int k;
      lf_at = -1;
      len   = 0;
      for (k = 0; k < int'(fill_cnt); k++) begin
         if (lf_at < 0 && text_store[ring_idx(k)] == CH_LF) lf_at = k;
      end
      if (lf_at > 0) begin
         len = (text_store[ring_idx(lf_at - 1)] == CH_CR) ? lf_at - 1 : lf_at;
      end
      if (len == 0) begin
         drop_eol();
         if (int'(fill_cnt) >= BUF_DEPTH) begin
            rd_pos   = '0;
            wr_pos   = '0;
            fill_cnt = '0;
         end
         expect_word(STAT_NOLINE, 8'h00, 1'b1, 0);
      end else begin
         for (k = 0; k < len; k++) begin
            expect_word(STAT_LINE, text_store[ring_idx(k)], k + 1 == len, len);
         end
         rd_pos   = ring_idx(len);
         fill_cnt = fill_cnt - CNT_W'(len);
         drop_eol();
      end
   endfunction

   function automatic void queue_word(logic c, logic [7:0] d);
      req_word_type w;
      w.drain = drain_next;
      w.cmd   = c;
      w.data  = d;
      drain_next = 1'b0;
      cmd_q.push_back(w);
   endfunction

   function automatic void queue_pop();
      queue_word(CMD_POP, 8'($urandom_range(0, 255)));
   endfunction

   // line content: never LF, sometimes CR
   function automatic logic [7:0] text_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 15) == 0) c = CH_CR;
      if (c == CH_LF) c = 8'h0B;
      return c;
   endfunction

   function automatic logic [7:0] noise_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return CH_LF;
      if (r < 25) return CH_CR;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) calm = $urandom_range(20, 80);
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // driver and consumer stall, both on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || accepted_cnt == offered_cnt) begin
            if (req_gap > 0) begin
               req_valid <= 1'b0;
               req_gap--;
            end else if (cmd_q.size() != 0 &&
                         (!cmd_q[0].drain ||
                          (line_words_q.size() == 0 && accepted_cnt == offered_cnt))) begin
               next_req = cmd_q.pop_front();
               req_valid   <= 1'b1;
               req_cmd     <= next_req.cmd;
               req_in_byte <= next_req.data;
               offered_cnt++;
               req_gap = pick_gap(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (rsp_gap > 0) begin
            rsp_stall <= 1'b1;
            rsp_gap--;
         end else begin
            rsp_stall <= 1'b0;
            rsp_gap = pick_gap(rsp_calm);
         end
      end
   end

   // monitor, predictor and watchdog on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (req_valid && !req_stall) begin
            accepted_cnt++;
            if (req_cmd == CMD_POP) begin
               framer_pop();
            end else begin
               framer_push(req_in_byte);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (line_words_q.size() == 0) begin
               $error("unexpected word: status %0d byte %02h last %0d length %0d",
                      rsp_status, rsp_out_byte, rsp_last, rsp_line_length);
               mismatch_seen = 1'b1;
            end else begin
               exp_word = line_words_q.pop_front();
               if (rsp_status !== exp_word.status) begin
                  $error("status: expected %0d, got %0d", exp_word.status, rsp_status);
                  mismatch_seen = 1'b1;
               end
               if (rsp_out_byte !== exp_word.data) begin
                  $error("out_byte: expected %02h, got %02h", exp_word.data, rsp_out_byte);
                  mismatch_seen = 1'b1;
               end
               if (rsp_last !== exp_word.last) begin
                  $error("last: expected %0d, got %0d", exp_word.last, rsp_last);
                  mismatch_seen = 1'b1;
               end
               if (rsp_line_length !== exp_word.len) begin
                  $error("line_length: expected %0d, got %0d", exp_word.len,
                         rsp_line_length);
                  mismatch_seen = 1'b1;
               end
            end
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("FAIL ring_buffer_line_extractor_core");
            $finish;
         end
      end
   end

   initial begin
      int directed_n;
      int kind;
      int n;
      int iter;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = CMD_PUSH;
      req_in_byte = 8'h00;
      rsp_stall   = 1'b0;
      rd_pos      = '0;
      wr_pos      = '0;
      fill_cnt    = '0;

      // directed
      queue_pop();
      queue_word(CMD_PUSH, 8'h00);
      queue_word(CMD_PUSH, 8'hFF);
      queue_word(CMD_PUSH, CH_CR);
      queue_word(CMD_PUSH, CH_LF);
      queue_pop();
      queue_word(CMD_PUSH, CH_LF);
      queue_pop();
      queue_word(CMD_PUSH, CH_CR);
      queue_word(CMD_PUSH, CH_LF);
      queue_pop();
      queue_word(CMD_PUSH, 8'h61);      // only the CR next to the LF goes
      queue_word(CMD_PUSH, CH_CR);
      queue_word(CMD_PUSH, CH_CR);
      queue_word(CMD_PUSH, CH_LF);
      queue_pop();
      queue_word(CMD_PUSH, 8'h62);      // incomplete line stays put
      queue_pop();
      queue_word(CMD_PUSH, CH_LF);
      queue_pop();
      queue_word(CMD_PUSH, CH_CR);      // leading CR is part of the line
      queue_word(CMD_PUSH, 8'h63);
      queue_word(CMD_PUSH, CH_LF);
      queue_pop();
      directed_n = cmd_q.size();

      // random sequences; first a full store, then a longest line
      drain_next = 1'b1;
      iter = 0;
      while (cmd_q.size() < directed_n + RAND_ITEMS) begin
         if (iter == 0) kind = 88;
         else if (iter == 1) kind = 91;
         else kind = $urandom_range(0, 99);
         iter++;
         if ($urandom_range(0, 49) == 0) drain_next = 1'b1;
         if (kind < 45) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            repeat (n) queue_word(CMD_PUSH, text_char());
            if ($urandom_range(0, 2) == 0) queue_word(CMD_PUSH, CH_CR);
            queue_word(CMD_PUSH, CH_LF);
            if ($urandom_range(0, 99) < 85) queue_pop();
            if ($urandom_range(0, 99) < 15) queue_pop();
         end else if (kind < 55) begin
            repeat ($urandom_range(1, 3)) begin
               queue_word(CMD_PUSH, $urandom_range(0, 1) ? CH_CR : CH_LF);
            end
            queue_pop();
         end else if (kind < 78) begin
            repeat ($urandom_range(1, 6)) begin
               queue_word($urandom_range(0, 3) == 0 ? CMD_POP : CMD_PUSH, noise_char());
            end
         end else if (kind < 88) begin
            queue_pop();
         end else if (kind < 94) begin
            queue_pop();
            queue_word(CMD_PUSH, CH_LF);
            queue_pop();
            if (kind < 91) begin
               repeat ($urandom_range(BUF_DEPTH, BUF_DEPTH + 3)) begin
                  queue_word(CMD_PUSH, text_char());
               end
            end else begin
               repeat (BUF_DEPTH - 1) queue_word(CMD_PUSH, text_char());
               if ($urandom_range(0, 1) == 0) queue_word(CMD_PUSH, CH_CR);
               queue_word(CMD_PUSH, CH_LF);
            end
            queue_pop();
         end else begin
            queue_pop();
            queue_pop();
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_q.size() != 0 || accepted_cnt != offered_cnt) @(posedge clock);
      while (line_words_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_seen) begin
         $display("FAIL ring_buffer_line_extractor_core");
      end else begin
         $display("PASS ring_buffer_line_extractor_core");
      end
      $finish;
   end

endmodule

@@ ring_buffer_line_extractor_core.f @@
design/rble_pkg.sv
design/ring_buffer_line_extractor_core.sv
bench/ring_buffer_line_extractor_core_tb.sv
